// ----- design/signed_64bit_divider_macros.svh -----
// ----------------------------------------------------------------------------
// signed_64bit_divider_macros
// assertion macros for the signed divider, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef SIGNED_64BIT_DIVIDER_MACROS_SVH
`define SIGNED_64BIT_DIVIDER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SDIV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("sdiv assertion failed");

// next-cycle implication
`define SDIV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("sdiv assertion failed");

`else

`define SDIV_ASSERT_NOW(label, ante, cons)
`define SDIV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/sdiv64_pkg.sv -----
// ----------------------------------------------------------------------------
// sdiv64_pkg
// widths shared by the signed divider
// ----------------------------------------------------------------------------
package sdiv64_pkg;

    // width of each operand and result field on the ports
    localparam int FIELD_WIDTH = 64;

    // default arithmetic width
    localparam int DATA_WIDTH_DEF = 64;

    localparam int S_TDATA_WIDTH = 2 * FIELD_WIDTH;
    localparam int M_TDATA_WIDTH = FIELD_WIDTH;

endpackage

// ----- design/signed_64bit_divider.sv -----
// ----------------------------------------------------------------------------
// signed_64bit_divider
// pipelined signed restoring divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one operand pair per transaction: s_tdata holds the
//   dividend in bits 63:0 and the divisor in bits 127:64. m_ channel returns
//   the quotient in m_tdata and the divide-by-zero flag in m_tuser.
//   only the low DATA_WIDTH bits of each operand are used; the quotient is
//   sign-extended to 64 bits. a zero divisor gives -1 for a non-negative
//   dividend and +1 for a negative one, with m_tuser set.
// structure: one stage takes magnitudes, one stage per quotient bit does a
//   compare-subtract, and an output register applies the sign.
// throughput: one transaction per cycle while the output is not stalled, set by the one-bit-per-stage chain.
// reset: aresetn low empties every stage and drops m_tvalid.
// stall: while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "signed_64bit_divider_macros.svh"

module signed_64bit_divider #(
    parameter int DATA_WIDTH = sdiv64_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sdiv64_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // dividend, divisor
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sdiv64_pkg::M_TDATA_WIDTH-1:0] m_tdata,  // quotient
    output logic                                 m_tuser   // divide_by_zero
);

    localparam int FW = sdiv64_pkg::FIELD_WIDTH;

    logic                  adv;
    logic [DATA_WIDTH:0]   vld_reg;
    logic [DATA_WIDTH:0]   neg_reg;
    logic [DATA_WIDTH:0]   dz_reg;
    logic [DATA_WIDTH-1:0] den_reg [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] num_reg [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_reg [0:DATA_WIDTH];

    logic [DATA_WIDTH-1:0] dvd_w;
    logic [DATA_WIDTH-1:0] dvs_w;
    logic [DATA_WIDTH-1:0] dvd_mag_next;
    logic [DATA_WIDTH-1:0] dvs_mag_next;

    logic                  m_tvalid_reg;
    logic [FW-1:0]         m_tdata_reg;
    logic                  m_tuser_reg;
    logic [DATA_WIDTH-1:0] quo_next;
    logic [FW-1:0]         m_tdata_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // magnitude stage
    always_comb begin
        dvd_w        = s_tdata[DATA_WIDTH-1:0];
        dvs_w        = s_tdata[FW+DATA_WIDTH-1:FW];
        dvd_mag_next = dvd_w[DATA_WIDTH-1] ? (~dvd_w + 1'b1) : dvd_w;
        dvs_mag_next = dvs_w[DATA_WIDTH-1] ? (~dvs_w + 1'b1) : dvs_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg_reg[0] <= dvd_w[DATA_WIDTH-1] ^ dvs_w[DATA_WIDTH-1];
            dz_reg[0]  <= (dvs_w == '0);
            den_reg[0] <= dvs_mag_next;
            num_reg[0] <= dvd_mag_next;
            rem_reg[0] <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        logic [DATA_WIDTH:0]   trial;
        logic [DATA_WIDTH:0]   diff;
        logic                  ge;
        logic [DATA_WIDTH-1:0] rem_next;
        logic [DATA_WIDTH-1:0] num_next;

        always_comb begin
            trial    = {rem_reg[k], num_reg[k][DATA_WIDTH-1]};
            diff     = trial - {1'b0, den_reg[k]};
            ge       = !diff[DATA_WIDTH];
            rem_next = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            num_next = {num_reg[k][DATA_WIDTH-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                neg_reg[k+1] <= neg_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
                den_reg[k+1] <= den_reg[k];
                num_reg[k+1] <= num_next;
                rem_reg[k+1] <= rem_next;
            end
        end
    end

    // sign and output register
    always_comb begin
        quo_next     = neg_reg[DATA_WIDTH] ? (~num_reg[DATA_WIDTH] + 1'b1)
                                           : num_reg[DATA_WIDTH];
        m_tdata_next = FW'($signed(quo_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld_reg[DATA_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= dz_reg[DATA_WIDTH];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `SDIV_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])
    `SDIV_ASSERT_NEXT(a_stall_holds, !s_tready, $stable(vld_reg) && m_tvalid)
    `SDIV_ASSERT_NOW(a_rem_below_den,
        vld_reg[DATA_WIDTH] && !dz_reg[DATA_WIDTH],
        rem_reg[DATA_WIDTH] < den_reg[DATA_WIDTH])
    `SDIV_ASSERT_NOW(a_dz_result, m_tvalid && m_tuser,
        (m_tdata == '1) || (m_tdata == FW'(1)))

endmodule
